[src/owt_pkg.sv]
// Shared types, codes and register defaults of the one-wire temperature reader.
package owt_pkg;

  localparam int TIMER_BITS_DEF = 20;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 20;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_HIGH   = 4'd2,
    PH_RST_LISTEN = 4'd3,
    PH_WR_LOW     = 4'd4,
    PH_WR_HOLD    = 4'd5,
    PH_WR_REC     = 4'd6,
    PH_RD_LOW     = 4'd7,
    PH_RD_REL     = 4'd8,
    PH_RD_TAIL    = 4'd9,
    PH_CONV       = 4'd10
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_RESET_LISTEN  = 3'd2,
    REG_SLOT_START    = 3'd3,
    REG_WRITE_SLOT    = 3'd4,
    REG_READ_SAMPLE   = 3'd5,
    REG_READ_TAIL     = 3'd6,
    REG_CONV_WAIT     = 3'd7
  } cfg_reg_t;

  localparam logic [2:0] STEP_RESET1   = 3'd0;
  localparam logic [2:0] STEP_SKIP1    = 3'd1;
  localparam logic [2:0] STEP_CONVERT  = 3'd2;
  localparam logic [2:0] STEP_CONVWAIT = 3'd3;
  localparam logic [2:0] STEP_SKIP2    = 3'd4;
  localparam logic [2:0] STEP_READCMD  = 3'd5;
  localparam logic [2:0] STEP_READ_LO  = 3'd6;
  localparam logic [2:0] STEP_READ_HI  = 3'd7;

  localparam logic [2:0] LAST_BIT = 3'd7;

  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_SCR  = 8'hBE;

  localparam logic [9:0]  RESET_LOW_DEF     = 10'd480;
  localparam logic [9:0]  RESET_RELEASE_DEF = 10'd70;
  localparam logic [9:0]  RESET_LISTEN_DEF  = 10'd410;
  localparam logic [5:0]  SLOT_START_DEF    = 6'd2;
  localparam logic [7:0]  WRITE_SLOT_DEF    = 8'd60;
  localparam logic [5:0]  READ_SAMPLE_DEF   = 6'd10;
  localparam logic [7:0]  READ_TAIL_DEF     = 8'd55;
  localparam logic [19:0] CONV_WAIT_DEF     = 20'd750000;

  localparam logic [7:0] DEG_MAX = 8'hFF;

endpackage

[src/owt_channels.sv]
// Valid/ready channel interfaces for the tick input and the result output.
interface owt_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_level;

  modport source (output valid, output start_req, output line_level, input ready);
  modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface owt_out_if;
  logic        valid;
  logic        ready;
  logic        drive_enable;
  logic        drive_level;
  logic        busy_res;
  logic        done_res;
  logic [15:0] raw_reading;
  logic [7:0]  temperature_c;

  modport source (output valid, output drive_enable, output drive_level, output busy_res,
                  output done_res, output raw_reading, output temperature_c, input ready);
  modport sink   (input valid, input drive_enable, input drive_level, input busy_res,
                  input done_res, input raw_reading, input temperature_c, output ready);
endinterface

[src/onewire_temperature_reader.sv]
// One-wire bus master that runs a convert and read sequence and reports the reading.
//
//   channel   dir   beat contents
//   in_bus    in    start_req, line_level (one beat per microsecond tick)
//   out_bus   out   drive_enable, drive_level, busy_res, done_res, raw_reading,
//                   temperature_c (one beat per input beat)
//   cfg_*     in    register index and data, written while cfg_we is high
//
// Each input beat is handled by the combinational phase logic and lands in the
// result register, so a new beat is taken every cycle while results drain.
// A beat is taken whenever the result register is empty or being emptied.
// Synchronous active-low reset returns the sequencer to idle and the timing
// registers to their defaults; no clearing pass is needed.
module onewire_temperature_reader #(
  parameter int TIMER_BITS = owt_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  owt_in_if.sink                             in_bus,
  owt_out_if.source                          out_bus,
  input  logic                               cfg_we,
  input  logic [owt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [owt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import owt_pkg::*;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [9:0]  reset_low_r, reset_release_r, reset_listen_r;
  logic [5:0]  slot_start_r, read_sample_r;
  logic [7:0]  write_slot_r, read_tail_r;
  logic [19:0] conv_wait_r;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [2:0]            bit_pos_r, bit_pos_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [7:0]            shifter_r, shifter_nxt;
  logic [15:0]           raw_r, raw_nxt;
  logic [7:0]            deg_r, deg_nxt;

  logic        out_valid_r;
  logic        de_r, dl_r, busy_r, done_r;
  logic [15:0] raw_out_r;
  logic [7:0]  deg_out_r;

  logic        de_c, dl_c, busy_c, done_c;
  logic        accept;
  logic [19:0] dur_src;
  logic [32:0] dur;
  logic        ends;
  logic [TIMER_BITS-1:0] timer_adv;
  logic        begin_c;
  logic [2:0]  begin_step;
  logic [11:0] deg_full;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= RESET_LOW_DEF;
      reset_release_r <= RESET_RELEASE_DEF;
      reset_listen_r  <= RESET_LISTEN_DEF;
      slot_start_r    <= SLOT_START_DEF;
      write_slot_r    <= WRITE_SLOT_DEF;
      read_sample_r   <= READ_SAMPLE_DEF;
      read_tail_r     <= READ_TAIL_DEF;
      conv_wait_r     <= CONV_WAIT_DEF;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RESET_LOW:     reset_low_r     <= cfg_data[9:0];
        REG_RESET_RELEASE: reset_release_r <= cfg_data[9:0];
        REG_RESET_LISTEN:  reset_listen_r  <= cfg_data[9:0];
        REG_SLOT_START:    slot_start_r    <= cfg_data[5:0];
        REG_WRITE_SLOT:    write_slot_r    <= cfg_data[7:0];
        REG_READ_SAMPLE:   read_sample_r   <= cfg_data[5:0];
        REG_READ_TAIL:     read_tail_r     <= cfg_data[7:0];
        REG_CONV_WAIT:     conv_wait_r     <= cfg_data;
      endcase
    end
  end

  always_comb begin
    case (phase_r)
      PH_RST_LOW:                      dur_src = 20'(reset_low_r);
      PH_RST_HIGH:                     dur_src = 20'(reset_release_r);
      PH_RST_LISTEN:                   dur_src = 20'(reset_listen_r);
      PH_CONV:                         dur_src = conv_wait_r;
      PH_WR_LOW, PH_WR_REC, PH_RD_LOW: dur_src = 20'(slot_start_r);
      PH_WR_HOLD:                      dur_src = 20'(write_slot_r);
      PH_RD_REL:                       dur_src = 20'(read_sample_r);
      PH_RD_TAIL:                      dur_src = 20'(read_tail_r);
      default:                         dur_src = 20'd0;
    endcase
    dur = 33'(dur_src);
    if (dur == 33'd0) begin
      dur = 33'd1;
    end
    if (dur > TMAX) begin
      dur = TMAX;
    end
    ends      = (33'(timer_r) + 33'd1) >= dur;
    timer_adv = ends ? '0 : timer_r + TIMER_BITS'(1);
  end

  always_comb begin
    unique case (phase_r)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: begin
        de_c = 1'b1; dl_c = 1'b0; busy_c = 1'b1;
      end
      PH_RST_HIGH, PH_CONV, PH_WR_REC: begin
        de_c = 1'b1; dl_c = 1'b1; busy_c = 1'b1;
      end
      PH_WR_HOLD: begin
        de_c = 1'b1; dl_c = shifter_r[0]; busy_c = 1'b1;
      end
      PH_RST_LISTEN, PH_RD_REL, PH_RD_TAIL: begin
        de_c = 1'b0; dl_c = 1'b0; busy_c = 1'b1;
      end
      default: begin
        de_c = 1'b0; dl_c = 1'b0; busy_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    bit_pos_nxt = bit_pos_r;
    step_nxt    = step_r;
    shifter_nxt = shifter_r;
    raw_nxt     = raw_r;
    deg_nxt     = deg_r;
    done_c      = 1'b0;
    begin_c     = 1'b0;
    begin_step  = STEP_RESET1;
    deg_full    = 12'd0;

    unique case (phase_r)
      PH_RST_LOW: begin
        timer_nxt = timer_adv;
        if (ends) phase_nxt = PH_RST_HIGH;
      end
      PH_RST_HIGH: begin
        timer_nxt = timer_adv;
        if (ends) phase_nxt = PH_RST_LISTEN;
      end
      PH_RST_LISTEN: begin
        timer_nxt = timer_adv;
        if (ends) begin
          begin_c    = 1'b1;
          begin_step = (step_r == STEP_RESET1) ? STEP_SKIP1 : STEP_SKIP2;
        end
      end
      PH_CONV: begin
        timer_nxt = timer_adv;
        if (ends) phase_nxt = PH_RST_LOW;
      end
      PH_WR_LOW: begin
        timer_nxt = timer_adv;
        if (ends) phase_nxt = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        timer_nxt = timer_adv;
        if (ends) phase_nxt = PH_WR_REC;
      end
      PH_WR_REC: begin
        timer_nxt = timer_adv;
        if (ends) begin
          shifter_nxt = shifter_r >> 1;
          if (bit_pos_r == LAST_BIT) begin
            begin_c    = 1'b1;
            begin_step = step_r + 3'd1;
          end else begin
            bit_pos_nxt = bit_pos_r + 3'd1;
            phase_nxt   = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        timer_nxt = timer_adv;
        if (ends) phase_nxt = PH_RD_REL;
      end
      PH_RD_REL: begin
        timer_nxt = timer_adv;
        if (ends) begin
          shifter_nxt = {in_bus.line_level, shifter_r[7:1]};
          phase_nxt   = PH_RD_TAIL;
        end
      end
      PH_RD_TAIL: begin
        timer_nxt = timer_adv;
        if (ends) begin
          if (bit_pos_r != LAST_BIT) begin
            bit_pos_nxt = bit_pos_r + 3'd1;
            phase_nxt   = PH_RD_LOW;
          end else if (step_r == STEP_READ_LO) begin
            raw_nxt    = {raw_r[15:8], shifter_r};
            begin_c    = 1'b1;
            begin_step = STEP_READ_HI;
          end else begin
            raw_nxt     = {shifter_r, raw_r[7:0]};
            deg_full    = raw_nxt[15:4];
            deg_nxt     = (deg_full[11:8] != 4'd0) ? DEG_MAX : deg_full[7:0];
            done_c      = 1'b1;
            phase_nxt   = PH_IDLE;
            step_nxt    = STEP_RESET1;
            bit_pos_nxt = 3'd0;
            timer_nxt   = '0;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_bus.start_req) begin
          begin_c    = 1'b1;
          begin_step = STEP_RESET1;
        end
      end
    endcase

    if (begin_c) begin
      step_nxt    = begin_step;
      bit_pos_nxt = 3'd0;
      timer_nxt   = '0;
      case (begin_step)
        STEP_RESET1:   phase_nxt = PH_RST_LOW;
        STEP_SKIP1, STEP_SKIP2: begin
          phase_nxt   = PH_WR_LOW;
          shifter_nxt = CMD_SKIP_ROM;
        end
        STEP_CONVERT: begin
          phase_nxt   = PH_WR_LOW;
          shifter_nxt = CMD_CONVERT;
        end
        STEP_CONVWAIT: phase_nxt = PH_CONV;
        STEP_READCMD: begin
          phase_nxt   = PH_WR_LOW;
          shifter_nxt = CMD_READ_SCR;
        end
        default: begin
          phase_nxt   = PH_RD_LOW;
          shifter_nxt = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      bit_pos_r   <= 3'd0;
      step_r      <= STEP_RESET1;
      shifter_r   <= 8'd0;
      raw_r       <= 16'd0;
      deg_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        timer_r   <= timer_nxt;
        bit_pos_r <= bit_pos_nxt;
        step_r    <= step_nxt;
        shifter_r <= shifter_nxt;
        raw_r     <= raw_nxt;
        deg_r     <= deg_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      de_r      <= de_c;
      dl_r      <= de_c & dl_c;
      busy_r    <= busy_c;
      done_r    <= done_c;
      raw_out_r <= raw_nxt;
      deg_out_r <= deg_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.drive_enable  = de_r;
  assign out_bus.drive_level   = dl_r;
  assign out_bus.busy_res      = busy_r;
  assign out_bus.done_res      = done_r;
  assign out_bus.raw_reading   = raw_out_r;
  assign out_bus.temperature_c = deg_out_r;

endmodule
